[design/bb3_pkg.sv]
package bb3_pkg;

  // Field widths fixed by the stream format.
  localparam int unsigned PIXEL_W   = 16;
  localparam int unsigned HSUM_W    = 15;
  localparam int unsigned OUT_COL_W = 11;
  localparam int unsigned ROW_W     = 16;
  localparam int unsigned WIDTH_W   = 12;
  localparam int unsigned HEIGHT_W  = 16;

  // Configuration port geometry.
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  // Reset values of the frame size registers.
  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd200;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd150;

  // Smallest frame dimension in use.
  localparam int unsigned MIN_DIM = 3;

  // Reciprocal of three, scaled by 2^17; exact for every 16-bit dividend.
  localparam logic [16:0] RECIP3       = 17'd43691;
  localparam int unsigned RECIP3_SHIFT = 17;

  // Register indexes, taken from address bit 2.
  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  // Truncating division of a 16-bit value by three.
  function automatic logic [PIXEL_W-1:0] div3(input logic [PIXEL_W-1:0] x);
    logic [PIXEL_W+16:0] prod;
    prod = {17'b0, x} * {16'b0, RECIP3};
    return prod[RECIP3_SHIFT +: PIXEL_W];
  endfunction

endpackage

[design/bb3_pix_if.sv]
interface bb3_pix_if import bb3_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);

endinterface

[design/bb3_out_if.sv]
interface bb3_out_if import bb3_pkg::*; ();

  logic                 valid;
  logic                 ready;
  logic [PIXEL_W-1:0]   blurred_pixel;
  logic [OUT_COL_W-1:0] out_column;
  logic [ROW_W-1:0]     out_row;
  logic                 last_pixel;

  modport source (output valid, output blurred_pixel, output out_column, output out_row,
                  output last_pixel, input ready);
  modport sink   (input valid, input blurred_pixel, input out_column, input out_row,
                  input last_pixel, output ready);

endinterface

[design/box_blur_3x3_stream_top.sv]
// Path: an input transaction passes the stage 1, stage 2 and output registers before
// its result appears on blur_o. Throughput: one pixel per cycle unless blur_o stalls;
// the combined line memory takes one read and one write per cycle, which sets that figure.
// Reset: counters, pipeline valids and the frame size registers (200 x 150) clear
// at once; the line memory is not cleared, each entry is written in rows 0 and 1.
module box_blur_3x3_stream_top import bb3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  bb3_pix_if.sink               pix_i,
  bb3_out_if.source             blur_o
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned MEM_W = 2 * HSUM_W;

  typedef struct packed {
    logic [OUT_COL_W-1:0] col;
    logic [ROW_W-1:0]     row;
    logic                 last;
  } meta_t;

  // Configuration registers.
  logic [WIDTH_W-1:0]  image_width_q;
  logic [HEIGHT_W-1:0] image_height_q;
  logic                cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= WIDTH_RESET;
      image_height_q <= HEIGHT_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_WIDTH:  image_width_q  <= pwdata[WIDTH_W-1:0];
        REG_HEIGHT: image_height_q <= pwdata[HEIGHT_W-1:0];
        default:    image_width_q  <= image_width_q;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_WIDTH:  prdata = {{(APB_DATA_W-WIDTH_W){1'b0}}, image_width_q};
      REG_HEIGHT: prdata = {{(APB_DATA_W-HEIGHT_W){1'b0}}, image_height_q};
      default:    prdata = '0;
    endcase
  end

  // Last column and last row of the frame, with the sizes clamped to their valid range.
  logic [31:0]         width_ext;
  logic [31:0]         col_last_ext;
  logic [CW-1:0]       col_last;
  logic [HEIGHT_W-1:0] row_last;

  assign width_ext = {{(32-WIDTH_W){1'b0}}, image_width_q};

  always_comb begin
    if (width_ext < MIN_DIM) begin
      col_last_ext = MIN_DIM - 1;
    end else if (width_ext > MAX_WIDTH) begin
      col_last_ext = MAX_WIDTH - 1;
    end else begin
      col_last_ext = width_ext - 32'd1;
    end
    col_last = col_last_ext[CW-1:0];
    if (image_height_q < HEIGHT_W'(MIN_DIM)) begin
      row_last = HEIGHT_W'(MIN_DIM - 1);
    end else begin
      row_last = image_height_q - 16'd1;
    end
  end

  // Pipeline handshake: each stage moves when the one after it can take its item.
  logic out_valid_q;
  logic s1_valid_q;
  logic s2_valid_q;
  logic out_en;
  logic s2_ready;
  logic s1_ready;
  logic acc;

  assign out_en       = !out_valid_q || blur_o.ready;
  assign s2_ready     = !s2_valid_q || out_en;
  assign s1_ready     = !s1_valid_q || s2_ready;
  assign pix_i.ready  = s1_ready;
  assign acc          = pix_i.valid && s1_ready;

  // Input position and the two previous pixels of the row.
  logic [CW-1:0]      col_q;
  logic [ROW_W-1:0]   row_q;
  logic [PIXEL_W-1:0] prev_one_q;
  logic [PIXEL_W-1:0] prev_two_q;
  logic               line_access;
  logic               has_output;
  logic [CW-1:0]      idx;
  logic [31:0]        idx_ext;
  logic [PIXEL_W-1:0] hsum_in;
  meta_t              meta_in;

  assign line_access = col_q > CW'(1);
  assign has_output  = row_q > 16'd1;
  assign idx         = col_q - CW'(2);
  assign idx_ext     = 32'(idx);
  assign hsum_in     = prev_one_q + prev_two_q + pix_i.pixel;
  assign meta_in     = '{col:  idx_ext[OUT_COL_W-1:0],
                         row:  row_q - 16'd2,
                         last: (col_q == col_last) && (row_q == row_last)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      prev_one_q <= '0;
      prev_two_q <= '0;
    end else if (cfg_we) begin
      col_q <= '0;
      row_q <= '0;
    end else if (acc) begin
      prev_two_q <= prev_one_q;
      prev_one_q <= pix_i.pixel;
      if (col_q == col_last) begin
        col_q <= '0;
        row_q <= (row_q == row_last) ? '0 : row_q + 16'd1;
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Stage 1 holds the horizontal sum while the line entry is read.
  logic [CW-1:0]      s1_idx_q;
  logic [PIXEL_W-1:0] s1_hsum_q;
  logic               s1_out_q;
  meta_t              s1_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= acc && line_access;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && line_access) begin
      s1_idx_q  <= idx;
      s1_hsum_q <= hsum_in;
      s1_out_q  <= has_output;
      s1_meta_q <= meta_in;
    end
  end

  // Line memory: each entry packs the older row's value above the newer one.
  // An entry is written as its item leaves stage 1, never later than the next
  // read, and consecutive accesses go to different entries, so no forwarding.
  logic [MEM_W-1:0]   line_mem [MAX_WIDTH];
  logic [MEM_W-1:0]   rd_q;
  logic [PIXEL_W-1:0] hval_full;
  logic [HSUM_W-1:0]  hval;
  logic               mem_we;
  logic               mem_re;

  assign hval_full = div3(s1_hsum_q);
  assign hval      = hval_full[HSUM_W-1:0];
  assign mem_we    = s1_valid_q && s2_ready;
  assign mem_re    = acc && line_access;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[s1_idx_q] <= {rd_q[HSUM_W-1:0], hval};
    end
    if (mem_re) begin
      rd_q <= line_mem[idx];
    end
  end

  // Stage 2 holds the three horizontal values of one output column.
  logic [HSUM_W-1:0] s2_older_q;
  logic [HSUM_W-1:0] s2_newer_q;
  logic [HSUM_W-1:0] s2_hval_q;
  meta_t             s2_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q && s1_out_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_older_q <= rd_q[MEM_W-1:HSUM_W];
      s2_newer_q <= rd_q[HSUM_W-1:0];
      s2_hval_q  <= hval;
      s2_meta_q  <= s1_meta_q;
    end
  end

  // Vertical sum and output register.
  logic [PIXEL_W-1:0] vsum;
  logic [PIXEL_W-1:0] blur_q;
  meta_t              out_meta_q;

  assign vsum = {1'b0, s2_older_q} + {1'b0, s2_newer_q} + {1'b0, s2_hval_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2_valid_q) begin
      blur_q     <= div3(vsum);
      out_meta_q <= s2_meta_q;
    end
  end

  assign blur_o.valid         = out_valid_q;
  assign blur_o.blurred_pixel = blur_q;
  assign blur_o.out_column    = out_meta_q.col;
  assign blur_o.out_row       = out_meta_q.row;
  assign blur_o.last_pixel    = out_meta_q.last;

`ifndef NO_ASSERTIONS
  // A line read never hits the entry being written in the same cycle.
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_we && mem_re) |-> (s1_idx_q != idx))
    else $error("line memory read and write collide on one entry");

  // An accepted pixel that touches the line memory occupies stage 1 next cycle.
  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && line_access && !cfg_we) |=> s1_valid_q)
    else $error("line access item lost before stage 1");

  // A stalled stage 1 keeps its item and its memory address.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s2_ready) |=> (s1_valid_q && $stable(s1_idx_q)))
    else $error("stage 1 item changed while stalled");
`endif

endmodule
